// ===== rtl/assert_macros.svh =====
// Assertion macros for the solver RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/cfs_pkg.sv =====
// Package for the 3x3 Cramer solver: default widths and the lane flag struct.
// No dependencies; used by all solver modules.
`timescale 1ns / 1ps

package cfs_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// Flags that travel with one quotient through the divider steps.
	typedef struct packed {
		logic neg;   // quotient is negative
		logic big;   // quotient magnitude is at least 2^DATA_WIDTH
		logic sing;  // denominator is zero
	} lane_flags_t;

endpackage

// ===== rtl/cramer_3x3_solver_core.sv =====
// Pipeline: DATA_WIDTH+8 register stages, from the determinant unit to the output register.
// Throughput: one system per cycle while the skid stage is empty (s_tready high),
// set by the fully pipelined determinant unit and the one-bit-per-stage dividers.
// Reset clears every valid bit and the skid stage; data registers are not reset.
// Top level of the 3x3 Cramer solver; depends on cfs_pkg, cfs_det_unit,
// cfs_quot_lane and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cramer_3x3_solver_core #(
	parameter int DATA_WIDTH = cfs_pkg::DATA_WIDTH,
	parameter int FRAC_BITS  = cfs_pkg::FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	// Input beat: a_r1c1, a_r1c2, a_r1c3, a_r2c1, a_r2c2, a_r2c3, a_r3c1,
	// a_r3c2, a_r3c3, b_1, b_2, b_3 from the lowest bit up, zero padded.
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((12*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
	// Result beat: x_1, x_2, x_3 from the lowest bit up, zero padded.
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [((3*DATA_WIDTH+7)/8)*8-1:0]       m_tdata,
	// Result flags: singular (bit 0), saturated (bit 1).
	output logic [1:0]                              m_tuser
);

	localparam int W    = DATA_WIDTH;
	localparam int DetW = 3 * DATA_WIDTH + 3;
	localparam int OutW = ((3 * DATA_WIDTH + 7) / 8) * 8;

	// The whole datapath advances together. It stalls only when the skid stage
	// is holding a beat, so the input side keeps taking beats while a single
	// finished result waits in the output register.
	logic en;
	logic skid_full_q;

	assign en       = ~skid_full_q;
	assign s_tready = en;

	// Unpack the input beat.
	logic signed [W-1:0] a_in [9];
	logic signed [W-1:0] b_in [3];

	for (genvar k = 0; k < 9; k++) begin : g_a
		assign a_in[k] = s_tdata[k*W +: W];
	end
	for (genvar t = 0; t < 3; t++) begin : g_bin
		assign b_in[t] = s_tdata[(9+t)*W +: W];
	end

	// Determinants: det_all[0] is det(A), det_all[j] has column j replaced by b.
	logic                  det_vld;
	logic signed [DetW-1:0] det_all [4];

	cfs_det_unit #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_det (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (s_tvalid & s_tready),
		.a_in    (a_in),
		.b_in    (b_in),
		.vld_out (det_vld),
		.det_out (det_all)
	);

	// Three quotient lanes divide in parallel by the same det(A).
	logic         lane_vld  [3];
	logic [W-1:0] lane_x    [3];
	logic         lane_sat  [3];
	logic         lane_sing [3];

	for (genvar j = 0; j < 3; j++) begin : g_lane
		cfs_quot_lane #(
			.DATA_WIDTH (DATA_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (det_vld),
			.num_in   (det_all[j+1]),
			.den_in   (det_all[0]),
			.vld_out  (lane_vld[j]),
			.x_out    (lane_x[j]),
			.sat_out  (lane_sat[j]),
			.sing_out (lane_sing[j])
		);
	end

	// A beat leaves the datapath only in a cycle in which it advances.
	logic            pipe_vld;
	logic [OutW-1:0] pipe_data;
	logic [1:0]      pipe_user;

	assign pipe_vld  = lane_vld[0] & lane_vld[1] & lane_vld[2] & en;
	assign pipe_data = OutW'({lane_x[2], lane_x[1], lane_x[0]});
	assign pipe_user = {lane_sat[0] | lane_sat[1] | lane_sat[2], lane_sing[0]};

	// Output register with one skid stage behind it.
	logic            m_tvalid_q;
	logic [OutW-1:0] m_tdata_q, skid_data_q;
	logic [1:0]      m_tuser_q, skid_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q  <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!m_tvalid_q || m_tready) begin
			if (skid_full_q) begin
				m_tvalid_q  <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				m_tvalid_q <= pipe_vld;
			end
		end else if (pipe_vld) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!m_tvalid_q || m_tready) begin
			if (skid_full_q) begin
				m_tdata_q <= skid_data_q;
				m_tuser_q <= skid_user_q;
			end else begin
				m_tdata_q <= pipe_data;
				m_tuser_q <= pipe_user;
			end
		end else if (pipe_vld) begin
			skid_data_q <= pipe_data;
			skid_user_q <= pipe_user;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// A singular system gives an all-zero solution and never reports clipping.
	`CFS_ASSERT_SAME(a_sing_zero, clk, arst_n, m_tvalid && m_tuser[0],
		m_tdata == '0 && !m_tuser[1])
	// The skid stage only fills behind an occupied output register.
	`CFS_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_full_q, m_tvalid_q)
	// The three lanes run in lockstep.
	`CFS_ASSERT_SAME(a_lanes_lockstep, clk, arst_n, lane_vld[0],
		lane_vld[1] && lane_vld[2])
	// A full skid stage drains into the output register on the next taken beat.
	`CFS_ASSERT_NEXT(a_skid_drain, clk, arst_n, skid_full_q && m_tready, !skid_full_q)

endmodule

// ===== rtl/cfs_det_unit.sv =====
// Determinant pipeline: det(A) and the three column-replaced determinants.
// Five register stages; depends on cfs_pkg.
`timescale 1ns / 1ps

module cfs_det_unit #(
	parameter int DATA_WIDTH = cfs_pkg::DATA_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_in,
	input  logic signed [DATA_WIDTH-1:0]    a_in [9],
	input  logic signed [DATA_WIDTH-1:0]    b_in [3],
	output logic                            vld_out,
	output logic signed [3*DATA_WIDTH+2:0]  det_out [4]
);

	localparam int W    = DATA_WIDTH;
	localparam int DetW = 3 * DATA_WIDTH + 3;

	logic signed [2*W-1:0] p1_s1 [9];
	logic signed [2*W-1:0] p2_s1 [9];
	logic signed [W-1:0]   a_s1 [9];
	logic signed [W-1:0]   b_s1 [3];
	logic signed [2*W:0]   cof_s2 [9];
	logic signed [W-1:0]   a_s2 [9];
	logic signed [W-1:0]   b_s2 [3];
	logic signed [2*W:0]   pl_s3 [12];
	logic signed [2*W:0]   ph_s3 [12];
	logic signed [3*W:0]   tp_s4 [12];
	logic signed [DetW-1:0] det_s5 [4];
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Cofactor of entry (r, c) from the cyclic 2x2 minor, which carries its own sign.
	for (genvar k = 0; k < 9; k++) begin : g_cof
		localparam int R  = k / 3;
		localparam int C  = k % 3;
		localparam int R1 = (R + 1) % 3;
		localparam int R2 = (R + 2) % 3;
		localparam int C1 = (C + 1) % 3;
		localparam int C2 = (C + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				p1_s1[k]  <= a_in[R1*3+C1] * a_in[R2*3+C2];
				p2_s1[k]  <= a_in[R1*3+C2] * a_in[R2*3+C1];
				a_s1[k]   <= a_in[k];
				cof_s2[k] <= (2*W+1)'(p1_s1[k]) - (2*W+1)'(p2_s1[k]);
				a_s2[k]   <= a_s1[k];
			end
		end
	end

	for (genvar t = 0; t < 3; t++) begin : g_b
		always_ff @(posedge clk) begin
			if (en) begin
				b_s1[t] <= b_in[t];
				b_s2[t] <= b_s1[t];
			end
		end
	end

	// Term t of determinant i: det(A) expands along row one, det_j along column j.
	for (genvar g = 0; g < 12; g++) begin : g_term
		localparam int I = g / 3;
		localparam int T = g % 3;
		logic signed [W-1:0] fac;
		logic signed [2*W:0] cof;
		logic        [W-1:0] lo;
		logic signed [W:0]   hi;
		if (I == 0) begin : g_row
			assign fac = a_s2[T];
			assign cof = cof_s2[T];
		end else begin : g_col
			assign fac = b_s2[T];
			assign cof = cof_s2[T*3+I-1];
		end
		assign lo = cof[W-1:0];
		assign hi = cof[2*W:W];
		always_ff @(posedge clk) begin
			if (en) begin
				pl_s3[g] <= fac * $signed({1'b0, lo});
				ph_s3[g] <= fac * hi;
				tp_s4[g] <= ((3*W+1)'(ph_s3[g]) <<< W) + (3*W+1)'(pl_s3[g]);
			end
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_sum
		always_ff @(posedge clk) begin
			if (en) begin
				det_s5[i] <= DetW'(tp_s4[3*i]) + DetW'(tp_s4[3*i+1])
					+ DetW'(tp_s4[3*i+2]);
			end
		end
		assign det_out[i] = det_s5[i];
	end

	assign vld_out = vld_s5;

endmodule

// ===== rtl/cfs_div_step.sv =====
// One restoring division step that resolves a single quotient bit.
// Depends on cfs_pkg for the flag struct.
`timescale 1ns / 1ps

module cfs_div_step #(
	parameter int DATA_WIDTH = cfs_pkg::DATA_WIDTH,
	parameter int FRAC_BITS  = cfs_pkg::FRAC_BITS,
	parameter int SHIFT      = 0
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic                                      vld_in,
	input  logic [4*DATA_WIDTH+FRAC_BITS+2:0]         rem_in,
	input  logic [3*DATA_WIDTH+2:0]                   den_in,
	input  logic [DATA_WIDTH-1:0]                     quo_in,
	input  cfs_pkg::lane_flags_t                      flags_in,
	output logic                                      vld_out,
	output logic [4*DATA_WIDTH+FRAC_BITS+2:0]         rem_out,
	output logic [3*DATA_WIDTH+2:0]                   den_out,
	output logic [DATA_WIDTH-1:0]                     quo_out,
	output cfs_pkg::lane_flags_t                      flags_out
);

	localparam int RemW = 4 * DATA_WIDTH + FRAC_BITS + 3;

	logic [RemW-1:0] den_sh;
	logic            take;

	assign den_sh = RemW'(den_in) << SHIFT;
	assign take   = rem_in >= den_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out   <= take ? rem_in - den_sh : rem_in;
			den_out   <= den_in;
			quo_out   <= quo_in | (DATA_WIDTH'(take) << SHIFT);
			flags_out <= flags_in;
		end
	end

endmodule

// ===== rtl/cfs_quot_lane.sv =====
// One quotient lane: magnitude setup, DATA_WIDTH division steps, sign and clip.
// Depends on cfs_pkg and cfs_div_step.
`timescale 1ns / 1ps

module cfs_quot_lane #(
	parameter int DATA_WIDTH = cfs_pkg::DATA_WIDTH,
	parameter int FRAC_BITS  = cfs_pkg::FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           vld_in,
	input  logic signed [3*DATA_WIDTH+2:0] num_in,
	input  logic signed [3*DATA_WIDTH+2:0] den_in,
	output logic                           vld_out,
	output logic [DATA_WIDTH-1:0]          x_out,
	output logic                           sat_out,
	output logic                           sing_out
);

	localparam int W    = DATA_WIDTH;
	localparam int DetW = 3 * DATA_WIDTH + 3;
	localparam int RemW = 4 * DATA_WIDTH + FRAC_BITS + 3;
	localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};

	logic [DetW-1:0]      num_abs, den_abs;
	logic [RemW-1:0]      num_sh;

	logic                 vld_c [W+1];
	logic [RemW-1:0]      rem_c [W+1];
	logic [DetW-1:0]      den_c [W+1];
	logic [W-1:0]         quo_c [W+1];
	cfs_pkg::lane_flags_t fl_c  [W+1];

	logic                 vld_q;
	logic [W-1:0]         x_q;
	logic                 sat_q, sing_q;

	assign num_abs = num_in[DetW-1] ? DetW'(-num_in) : DetW'(num_in);
	assign den_abs = den_in[DetW-1] ? DetW'(-den_in) : DetW'(den_in);
	assign num_sh  = RemW'(num_abs) << FRAC_BITS;

	// Setup stage: scaled numerator, divisor and the early overflow test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else if (en) begin
			vld_c[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_c[0]      <= num_sh;
			den_c[0]      <= den_abs;
			quo_c[0]      <= '0;
			fl_c[0].neg   <= num_in[DetW-1] ^ den_in[DetW-1];
			fl_c[0].big   <= num_sh >= (RemW'(den_abs) << W);
			fl_c[0].sing  <= den_in == '0;
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_step
		cfs_div_step #(
			.DATA_WIDTH (DATA_WIDTH),
			.FRAC_BITS  (FRAC_BITS),
			.SHIFT      (W - 1 - k)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.vld_in    (vld_c[k]),
			.rem_in    (rem_c[k]),
			.den_in    (den_c[k]),
			.quo_in    (quo_c[k]),
			.flags_in  (fl_c[k]),
			.vld_out   (vld_c[k+1]),
			.rem_out   (rem_c[k+1]),
			.den_out   (den_c[k+1]),
			.quo_out   (quo_c[k+1]),
			.flags_out (fl_c[k+1])
		);
	end

	// Sign and clip stage. The remainder past the last step is not needed.
	logic [W-1:0]         mag;
	cfs_pkg::lane_flags_t fl;
	logic                 neg_over, pos_over;

	assign mag      = quo_c[W];
	assign fl       = fl_c[W];
	assign neg_over = fl.big | (mag[W-1] & (|mag[W-2:0]));
	assign pos_over = fl.big | mag[W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_c[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_q <= fl.sing;
			if (fl.sing) begin
				x_q   <= '0;
				sat_q <= 1'b0;
			end else if (fl.neg) begin
				x_q   <= neg_over ? MinNeg : W'(-mag);
				sat_q <= neg_over;
			end else begin
				x_q   <= pos_over ? MaxPos : mag;
				sat_q <= pos_over;
			end
		end
	end

	assign vld_out  = vld_q;
	assign x_out    = x_q;
	assign sat_out  = sat_q;
	assign sing_out = sing_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the 3x3 Cramer solver core: directed systems, then random ones.
// Depends on cfs_pkg and the RTL of cramer_3x3_solver_core; checks against typed solutions and its own predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int DW   = cfs_pkg::DATA_WIDTH;
	localparam int FB   = cfs_pkg::FRAC_BITS;
	localparam int SW   = ((12*DW+7)/8)*8;
	localparam int MW   = ((3*DW+7)/8)*8;
	localparam int NUM_RANDOM = 935;
	localparam int DRAIN_CYCLES = 3*DW;
	localparam logic [DW-1:0] Q_ONE = 1 << FB;
	localparam logic [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

	typedef logic signed [159:0] wide_t;

	typedef struct {
		logic [DW-1:0] x [3];
		logic          singular;
		logic          saturated;
	} solution_t;

	typedef struct {
		logic [SW-1:0] sys;
		bit            typed;
		solution_t     sol;
	} sys_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [MW-1:0] m_tdata;
	logic [1:0]    m_tuser;

	sys_row_t  systems [$];
	solution_t solutions_due [$];
	int        beat_idx = 0;
	int        accept_idx = 0;
	int        fail_count = 0;
	bit        feed_done = 1'b0;

	cramer_3x3_solver_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Exact 3x3 determinant by Sarrus; m is row-major.
	function automatic wide_t det_sarrus(input wide_t m [9]);
		return m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
			- m[2]*m[4]*m[6] - m[1]*m[3]*m[8] - m[0]*m[5]*m[7];
	endfunction

	function automatic solution_t solve_cramer(input logic [SW-1:0] sys);
		wide_t     a [9];
		wide_t     m [9];
		wide_t     b [3];
		wide_t     den, q;
		solution_t s;
		for (int i = 0; i < 9; i++) a[i] = $signed(sys[DW*i +: DW]);
		for (int i = 0; i < 3; i++) b[i] = $signed(sys[DW*(9+i) +: DW]);
		den = det_sarrus(a);
		s.saturated = 1'b0;
		s.singular  = (den == 0);
		for (int col = 0; col < 3; col++) begin
			s.x[col] = '0;
			if (!s.singular) begin
				m = a;
				for (int row = 0; row < 3; row++) m[row*3+col] = b[row];
				// Signed division truncates toward zero, as the block does.
				q = (det_sarrus(m) <<< FB) / den;
				if (q > $signed({1'b0, S_MAX})) begin
					s.x[col] = S_MAX;
					s.saturated = 1'b1;
				end else if (q < -$signed({1'b0, S_MIN})) begin
					s.x[col] = S_MIN;
					s.saturated = 1'b1;
				end else begin
					s.x[col] = q[DW-1:0];
				end
			end
		end
		return s;
	endfunction

	function automatic logic [SW-1:0] pack_system(input logic [DW-1:0] f [12]);
		logic [SW-1:0] v;
		v = '0;
		for (int i = 0; i < 12; i++) v[DW*i +: DW] = f[i];
		return v;
	endfunction

	function automatic void add_row(input logic [DW-1:0] f [12], input bit typed,
			input logic [DW-1:0] x1, input logic [DW-1:0] x2, input logic [DW-1:0] x3,
			input logic sing, input logic sat);
		sys_row_t r;
		r.sys = pack_system(f);
		r.typed = typed;
		r.sol.x[0] = x1;
		r.sol.x[1] = x2;
		r.sol.x[2] = x3;
		r.sol.singular = sing;
		r.sol.saturated = sat;
		systems.push_back(r);
	endfunction

	function automatic logic [DW-1:0] pick_value(input int kind);
		case (kind)
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			3: return Q_ONE;
			4: return -Q_ONE;
			5: return 1;
			default: return $urandom;
		endcase
	endfunction

	function automatic void build_stimulus();
		logic [DW-1:0] f [12];
		int kind;
		// Zero matrix is singular: zero solution, singular flag.
		f = '{default: '0}; f[9] = Q_ONE; f[10] = S_MAX; f[11] = S_MIN;
		add_row(f, 1, 0, 0, 0, 1, 0);
		// Identity passes b straight through.
		f = '{default: '0}; f[0] = Q_ONE; f[4] = Q_ONE; f[8] = Q_ONE;
		f[9] = Q_ONE; f[10] = 2*Q_ONE; f[11] = -3*Q_ONE;
		add_row(f, 1, Q_ONE, 2*Q_ONE, -3*Q_ONE, 0, 0);
		f[9] = S_MAX; f[10] = S_MIN; f[11] = 1;
		add_row(f, 1, S_MAX, S_MIN, 1, 0, 0);
		// Tiny diagonal: the first two quotients overflow both ways and clip.
		f = '{default: '0}; f[0] = 1; f[4] = 1; f[8] = 1;
		f[9] = S_MAX; f[10] = S_MIN; f[11] = 1;
		add_row(f, 1, S_MAX, S_MIN, Q_ONE, 0, 1);
		// All entries at one extreme: rows are equal, so singular.
		f = '{default: S_MAX};
		add_row(f, 1, 0, 0, 0, 1, 0);
		f = '{default: S_MIN};
		add_row(f, 1, 0, 0, 0, 1, 0);
		// Most negative diagonal and b: every x is exactly one.
		f = '{default: '0}; f[0] = S_MIN; f[4] = S_MIN; f[8] = S_MIN;
		f[9] = S_MIN; f[10] = S_MIN; f[11] = S_MIN;
		add_row(f, 1, Q_ONE, Q_ONE, Q_ONE, 0, 0);
		// Remaining directed rows come from the predictor.
		f = '{default: '0}; f[0] = S_MAX; f[4] = S_MAX; f[8] = S_MAX;
		f[9] = S_MIN; f[10] = S_MAX; f[11] = 5;
		add_row(f, 0, 0, 0, 0, 0, 0);
		f = '{default: '0}; f[0] = -Q_ONE; f[4] = -Q_ONE; f[8] = -Q_ONE;
		f[9] = Q_ONE; f[10] = -Q_ONE; f[11] = 7;
		add_row(f, 0, 0, 0, 0, 0, 0);
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 12; i++) f[i] = pick_value($urandom_range(0, 6));
			add_row(f, 0, 0, 0, 0, 0, 0);
		end

		for (int n = 0; n < NUM_RANDOM; n++) begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 12; i++) begin
				if (kind < 4) f[i] = $urandom;
				else if (kind < 7) f[i] = $urandom_range(0, 1 << (FB+3)) - (1 << (FB+2));
				else f[i] = pick_value($urandom_range(0, 8));
			end
			if (kind == 7) begin
				// Singular: a repeated row or a zero column.
				if ($urandom_range(0, 1)) begin
					f[6] = f[0]; f[7] = f[1]; f[8] = f[2];
				end else begin
					f[1] = '0; f[4] = '0; f[7] = '0;
				end
			end else if (kind == 8) begin
				// Near-singular diagonal with large b drives saturation.
				f[1] = '0; f[2] = '0; f[3] = '0; f[5] = '0; f[6] = '0; f[7] = '0;
				f[0] = $urandom_range(1, 255); f[4] = $urandom_range(1, 255);
				f[8] = -$urandom_range(1, 255);
			end
			add_row(f, 0, 0, 0, 0, 0, 0);
		end
	endfunction

	// Sender: bursts of random length, random gaps, one pause to drain.
	initial begin
		int burst_left;
		int gap;
		build_stimulus();
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (beat_idx < systems.size()) begin
			if (beat_idx == systems.size() / 2) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (solutions_due.size() != 0) @(posedge clk);
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
					: $urandom_range(1, 12);
				gap = $urandom_range(0, 5);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			s_tvalid <= 1'b1;
			s_tdata  <= systems[beat_idx].sys;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			beat_idx++;
			burst_left--;
		end
		s_tvalid <= 1'b0;
		feed_done = 1'b1;
	end

	// Receiver: mixed stall pattern, with one long hold-off to back the pipe up.
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0) mode = $urandom_range(0, 3);
			if (cyc >= 400 && cyc < 700) m_tready <= 1'b0;
			else if (mode == 0) m_tready <= 1'b1;
			else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
			else if (mode == 2) m_tready <= ($urandom_range(0, 3) == 0);
			else m_tready <= cyc[2];
		end
	end

	// Expectation for every system accepted by the core, counted here on its own.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			if (systems[accept_idx].typed) solutions_due.push_back(systems[accept_idx].sol);
			else solutions_due.push_back(solve_cramer(s_tdata));
			accept_idx++;
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		solution_t want;
		if (m_tvalid && m_tready) begin
			if (solutions_due.size() == 0) begin
				$display("%0t: unexpected result beat data=%h user=%b", $time, m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = solutions_due.pop_front();
				for (int i = 0; i < 3; i++)
					if (m_tdata[DW*i +: DW] !== want.x[i]) begin
						$display("%0t: x_%0d expected %h actual %h", $time, i+1, want.x[i],
							m_tdata[DW*i +: DW]);
						fail_count++;
					end
				if (m_tuser[0] !== want.singular) begin
					$display("%0t: singular expected %b actual %b", $time, want.singular,
						m_tuser[0]);
					fail_count++;
				end
				if (m_tuser[1] !== want.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time, want.saturated,
						m_tuser[1]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		wait (feed_done);
		while (solutions_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cfs_pkg.sv
rtl/cfs_det_unit.sv
rtl/cfs_div_step.sv
rtl/cfs_quot_lane.sv
rtl/cramer_3x3_solver_core.sv
tb/testbench.sv
